// ===== rtl/dark_theme_pixel_lift_top_assert.svh =====
// Assertion macros for the pixel lift block.
// Define NO_ASSERTIONS to compile the checks away.
`ifndef DARK_THEME_PIXEL_LIFT_TOP_ASSERT_SVH
`define DARK_THEME_PIXEL_LIFT_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// The condition must hold in the same cycle as the trigger.
`define DTPL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dark_theme_pixel_lift_top: same-cycle check failed");
// The condition must hold in the cycle after the trigger.
`define DTPL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dark_theme_pixel_lift_top: next-cycle check failed");
`else
`define DTPL_ASSERT_NOW(lbl, ante, cons)
`define DTPL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/dtpl_pkg.sv =====
package dtpl_pkg;

    localparam int DTPL_CH_W       = 8;
    localparam int DTPL_STR_W      = 17;
    localparam int DTPL_CFG_W      = 17;
    localparam int DTPL_CFG_ADDR_W = 2;
    localparam int DTPL_LANES      = 3;
    localparam int DTPL_Q16_SHIFT  = 16;

    // Amount division: strength * (cutoff - v) / cutoff.
    localparam int DTPL_AMT_NUM_W = DTPL_STR_W + DTPL_CH_W;
    localparam int DTPL_AMT_Q_W   = DTPL_STR_W;

    // Lifted brightness in Q16 after clamping at zero.
    localparam int DTPL_POS_W = 25;

    // Channel scaling: (2*c*pos + v*2^16) >> 17, then divided by v.
    localparam int DTPL_SCL_FULL_W = DTPL_POS_W + DTPL_CH_W + 1;
    localparam int DTPL_SCL_NUM_W  = DTPL_SCL_FULL_W - (DTPL_Q16_SHIFT + 1);
    localparam int DTPL_SCL_Q_W    = DTPL_CH_W + 1;

    localparam logic [DTPL_CH_W-1:0]  DTPL_CUTOFF_RST   = 8'd192;
    localparam logic [DTPL_CH_W-1:0]  DTPL_TARGET_RST   = 8'd224;
    localparam logic [DTPL_STR_W-1:0] DTPL_STRENGTH_RST = 17'd53740;
    localparam logic                  DTPL_ALPHA_RST    = 1'b1;

    typedef enum logic [DTPL_CFG_ADDR_W-1:0] {
        DTPL_REG_CUTOFF   = 2'd0,
        DTPL_REG_TARGET   = 2'd1,
        DTPL_REG_STRENGTH = 2'd2,
        DTPL_REG_ALPHA    = 2'd3
    } dtpl_reg_t;

    typedef struct packed {
        logic [DTPL_CH_W-1:0]  cutoff;
        logic [DTPL_CH_W-1:0]  target;
        logic [DTPL_STR_W-1:0] strength;
        logic                  alpha_present;
    } dtpl_cfg_t;

    typedef struct packed {
        logic [DTPL_CH_W-1:0] red;
        logic [DTPL_CH_W-1:0] green;
        logic [DTPL_CH_W-1:0] blue;
    } dtpl_pix_t;

    // Travels alongside the amount division.
    typedef struct packed {
        dtpl_pix_t            pix;
        logic [DTPL_CH_W-1:0] v;
        logic                 pass;
    } dtpl_front_t;

    // Travels alongside the channel division.
    typedef struct packed {
        dtpl_pix_t pix;
        logic      pass;
    } dtpl_tail_t;

    localparam int DTPL_FRONT_W = $bits(dtpl_front_t);
    localparam int DTPL_TAIL_W  = $bits(dtpl_tail_t);

    function automatic logic [DTPL_CH_W-1:0] dtpl_sat8(input logic [DTPL_SCL_Q_W-1:0] q);
        return q[DTPL_SCL_Q_W-1] ? {DTPL_CH_W{1'b1}} : q[DTPL_CH_W-1:0];
    endfunction

endpackage

// ===== rtl/dark_theme_pixel_lift_top.sv =====
// Dark theme pixel lift. Each request on the s_ channel carries one RGB pixel
// with its alpha; the m_ channel returns one RGB pixel per request, in order.
// Pixels that are transparent (alpha present and zero) or whose brightness,
// the largest channel, is at or above lift_cutoff come out unchanged. Darker
// pixels have their brightness pulled toward lift_target by a Q16 strength
// that grows as the pixel gets darker; all three channels are scaled by the
// same factor, so hue is kept, and black becomes an even grey. Results round
// half up and saturate at 255. The block takes one pixel per clock while
// s_ready is high. Most of the pipeline depth comes from the two pipelined
// dividers, which resolve one quotient bit per stage (17 stages for the pull
// amount, 9 for the channel scaling). Registers are written through cfg_we,
// cfg_addr and cfg_wdata; the user must write them only while no pixel is
// in flight, which the block itself does not enforce. Index 0 lift_cutoff,
// 1 lift_target, 2 lift_strength, 3 alpha_present.
`include "dark_theme_pixel_lift_top_assert.svh"

module dark_theme_pixel_lift_top (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [dtpl_pkg::DTPL_CH_W-1:0]        s_red,
    input  logic [dtpl_pkg::DTPL_CH_W-1:0]        s_green,
    input  logic [dtpl_pkg::DTPL_CH_W-1:0]        s_blue,
    input  logic [dtpl_pkg::DTPL_CH_W-1:0]        s_opacity,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [dtpl_pkg::DTPL_CH_W-1:0]        m_red_out,
    output logic [dtpl_pkg::DTPL_CH_W-1:0]        m_green_out,
    output logic [dtpl_pkg::DTPL_CH_W-1:0]        m_blue_out,

    input  logic                                  cfg_we,
    input  logic [dtpl_pkg::DTPL_CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dtpl_pkg::DTPL_CFG_W-1:0]       cfg_wdata
);

    // Configuration registers. The user must change them only while the pipeline
    // is empty; the block itself does not enforce this, and every stage reads them directly.
    dtpl_pkg::dtpl_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cutoff        <= dtpl_pkg::DTPL_CUTOFF_RST;
            cfg_reg.target        <= dtpl_pkg::DTPL_TARGET_RST;
            cfg_reg.strength      <= dtpl_pkg::DTPL_STRENGTH_RST;
            cfg_reg.alpha_present <= dtpl_pkg::DTPL_ALPHA_RST;
        end else if (cfg_we) begin
            case (dtpl_pkg::dtpl_reg_t'(cfg_addr))
                dtpl_pkg::DTPL_REG_CUTOFF: begin
                    cfg_reg.cutoff <= cfg_wdata[dtpl_pkg::DTPL_CH_W-1:0];
                end
                dtpl_pkg::DTPL_REG_TARGET: begin
                    cfg_reg.target <= cfg_wdata[dtpl_pkg::DTPL_CH_W-1:0];
                end
                dtpl_pkg::DTPL_REG_STRENGTH: begin
                    cfg_reg.strength <= cfg_wdata[dtpl_pkg::DTPL_STR_W-1:0];
                end
                dtpl_pkg::DTPL_REG_ALPHA: begin
                    cfg_reg.alpha_present <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline advances together whenever the skid register is
    // empty. Since the skid only fills while the output register holds a
    // result, a stalled consumer never drops or repeats a pixel, and the
    // input keeps flowing while one finished result waits.
    logic en;
    logic skid_valid_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    dtpl_pkg::dtpl_pix_t in_pix;

    assign in_pix.red   = s_red;
    assign in_pix.green = s_green;
    assign in_pix.blue  = s_blue;

    // Front end: brightness, pass decision and the amount dividend.
    logic                                  front_valid;
    logic [dtpl_pkg::DTPL_AMT_NUM_W-1:0]   front_num;
    dtpl_pkg::dtpl_front_t                 front_side;

    dtpl_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .in_pix     (in_pix),
        .in_opacity (s_opacity),
        .cfg        (cfg_reg),
        .out_valid  (front_valid),
        .out_num    (front_num),
        .out_side   (front_side)
    );

    // Pull amount: strength * (cutoff - v) / cutoff, truncated.
    logic                                  amt_valid;
    logic [0:0][dtpl_pkg::DTPL_AMT_Q_W-1:0] amt_quo;
    dtpl_pkg::dtpl_front_t                 amt_side;

    dtpl_div_pipe #(
        .LANES  (1),
        .NUM_W  (dtpl_pkg::DTPL_AMT_NUM_W),
        .DEN_W  (dtpl_pkg::DTPL_CH_W),
        .Q_W    (dtpl_pkg::DTPL_AMT_Q_W),
        .SIDE_W (dtpl_pkg::DTPL_FRONT_W)
    ) u_div_amount (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in_num    (front_num),
        .in_den    (cfg_reg.cutoff),
        .in_side   (front_side),
        .out_valid (amt_valid),
        .out_quo   (amt_quo),
        .out_side  (amt_side)
    );

    // Lift: lifted brightness, then one dividend per channel.
    logic                                  lift_valid;
    logic [dtpl_pkg::DTPL_LANES-1:0][dtpl_pkg::DTPL_SCL_NUM_W-1:0] lift_num;
    logic [dtpl_pkg::DTPL_CH_W-1:0]        lift_den;
    dtpl_pkg::dtpl_tail_t                  lift_side;

    dtpl_lift u_lift (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (amt_valid),
        .in_amount (amt_quo[0]),
        .in_side   (amt_side),
        .cfg       (cfg_reg),
        .out_valid (lift_valid),
        .out_num   (lift_num),
        .out_den   (lift_den),
        .out_side  (lift_side)
    );

    // Channel scaling: three lanes share one divisor, the brightness (one for black).
    logic                                  divb_valid;
    logic [dtpl_pkg::DTPL_LANES-1:0][dtpl_pkg::DTPL_SCL_Q_W-1:0] divb_quo;
    dtpl_pkg::dtpl_tail_t                  divb_side;

    dtpl_div_pipe #(
        .LANES  (dtpl_pkg::DTPL_LANES),
        .NUM_W  (dtpl_pkg::DTPL_SCL_NUM_W),
        .DEN_W  (dtpl_pkg::DTPL_CH_W),
        .Q_W    (dtpl_pkg::DTPL_SCL_Q_W),
        .SIDE_W (dtpl_pkg::DTPL_TAIL_W)
    ) u_div_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (lift_valid),
        .in_num    (lift_num),
        .in_den    (lift_den),
        .in_side   (lift_side),
        .out_valid (divb_valid),
        .out_quo   (divb_quo),
        .out_side  (divb_side)
    );

    // Last pipeline stage: saturate the quotients, or pick the original
    // pixel when it passes unchanged.
    logic                res_valid_reg;
    dtpl_pkg::dtpl_pix_t res_pix_reg;
    dtpl_pkg::dtpl_pix_t res_pix_next;

    always_comb begin
        if (divb_side.pass) begin
            res_pix_next = divb_side.pix;
        end else begin
            res_pix_next.red   = dtpl_pkg::dtpl_sat8(divb_quo[0]);
            res_pix_next.green = dtpl_pkg::dtpl_sat8(divb_quo[1]);
            res_pix_next.blue  = dtpl_pkg::dtpl_sat8(divb_quo[2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (en) begin
            res_valid_reg <= divb_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_pix_reg <= res_pix_next;
        end
    end

    // Output register with a skid register behind it. When the output is
    // free, the skid drains first; otherwise the pipeline result goes out
    // directly. When the output is held, a result leaving the pipeline is
    // parked in the skid, which then stalls the pipeline.
    logic                m_valid_reg;
    dtpl_pkg::dtpl_pix_t m_pix_reg;
    dtpl_pkg::dtpl_pix_t skid_pix_reg;
    logic                out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                m_pix_reg      <= skid_pix_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= res_valid_reg;
                m_pix_reg   <= res_pix_reg;
            end
        end else if (res_valid_reg && en) begin
            skid_valid_reg <= 1'b1;
            skid_pix_reg   <= res_pix_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_red_out   = m_pix_reg.red;
    assign m_green_out = m_pix_reg.green;
    assign m_blue_out  = m_pix_reg.blue;

    // The skid only ever holds a result behind a waiting output.
    `DTPL_ASSERT_NOW(a_skid_behind_output, skid_valid_reg, m_valid_reg)
    // A result leaving the pipeline into a held output must land in the skid.
    `DTPL_ASSERT_NEXT(a_skid_catches, m_valid_reg && !m_ready && res_valid_reg && en, skid_valid_reg)
    // A passing pixel reaches the last stage bit for bit.
    `DTPL_ASSERT_NEXT(a_pass_unchanged, en && divb_valid && divb_side.pass, res_pix_reg == $past(divb_side.pix))

endmodule

// ===== rtl/dtpl_front.sv =====
module dtpl_front (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      en,
    input  logic                                      in_valid,
    input  dtpl_pkg::dtpl_pix_t                       in_pix,
    input  logic [dtpl_pkg::DTPL_CH_W-1:0]            in_opacity,
    input  dtpl_pkg::dtpl_cfg_t                       cfg,
    output logic                                      out_valid,
    output logic [dtpl_pkg::DTPL_AMT_NUM_W-1:0]       out_num,
    output dtpl_pkg::dtpl_front_t                     out_side
);

    logic                                s1_valid_reg;
    dtpl_pkg::dtpl_front_t               s1_reg;
    dtpl_pkg::dtpl_front_t               s1_next;
    logic [dtpl_pkg::DTPL_CH_W-1:0]      v_max;

    logic                                s2_valid_reg;
    dtpl_pkg::dtpl_front_t               s2_reg;
    logic [dtpl_pkg::DTPL_CH_W-1:0]      span;
    logic [dtpl_pkg::DTPL_AMT_NUM_W-1:0] num_reg;
    logic [dtpl_pkg::DTPL_AMT_NUM_W-1:0] num_next;

    // Stage one: brightness and the pass decision.
    always_comb begin
        v_max = in_pix.red;
        if (in_pix.green > v_max) begin
            v_max = in_pix.green;
        end
        if (in_pix.blue > v_max) begin
            v_max = in_pix.blue;
        end
        s1_next.pix  = in_pix;
        s1_next.v    = v_max;
        s1_next.pass = (cfg.alpha_present && (in_opacity == '0)) || (v_max >= cfg.cutoff);
    end

    // Stage two: dividend of the amount division. Passing pixels may wrap here;
    // their result is discarded at the end.
    always_comb begin
        span     = cfg.cutoff - s1_reg.v;
        num_next = dtpl_pkg::DTPL_AMT_NUM_W'(cfg.strength)
                 * dtpl_pkg::DTPL_AMT_NUM_W'(span);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg  <= s1_next;
            s2_reg  <= s1_reg;
            num_reg <= num_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_num   = num_reg;
    assign out_side  = s2_reg;

endmodule

// ===== rtl/dtpl_div_pipe.sv =====
module dtpl_div_pipe #(
    parameter int LANES  = dtpl_pkg::DTPL_LANES,
    parameter int NUM_W  = dtpl_pkg::DTPL_SCL_NUM_W,
    parameter int DEN_W  = dtpl_pkg::DTPL_CH_W,
    parameter int Q_W    = dtpl_pkg::DTPL_SCL_Q_W,
    parameter int SIDE_W = dtpl_pkg::DTPL_TAIL_W
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [LANES-1:0][NUM_W-1:0]     in_num,
    input  logic [DEN_W-1:0]                in_den,
    input  logic [SIDE_W-1:0]               in_side,
    output logic                            out_valid,
    output logic [LANES-1:0][Q_W-1:0]       out_quo,
    output logic [SIDE_W-1:0]               out_side
);

    // Restoring division, one quotient bit per stage, most significant first.
    // The caller guarantees that the quotient fits in Q_W bits.
    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [Q_W-1:0]                         vld_reg;
    logic [LANES-1:0][NUM_W-1:0]            rem_reg  [Q_W];
    logic [LANES-1:0][Q_W-1:0]              quo_reg  [Q_W];
    logic [DEN_W-1:0]                       den_reg  [Q_W];
    logic [SIDE_W-1:0]                      side_reg [Q_W];

    logic [Q_W-1:0]                         vld_in;
    logic [LANES-1:0][NUM_W-1:0]            rem_in   [Q_W];
    logic [LANES-1:0][Q_W-1:0]              quo_in   [Q_W];
    logic [DEN_W-1:0]                       den_in   [Q_W];
    logic [SIDE_W-1:0]                      side_in  [Q_W];
    logic [LANES-1:0][NUM_W-1:0]            rem_next [Q_W];
    logic [LANES-1:0][Q_W-1:0]              quo_next [Q_W];

    for (genvar gs = 0; gs < Q_W; gs++) begin : g_stage
        localparam int K = Q_W - 1 - gs;
        logic [CW-1:0] den_sh;

        if (gs == 0) begin : g_first
            assign vld_in[gs]  = in_valid;
            assign rem_in[gs]  = in_num;
            assign quo_in[gs]  = '0;
            assign den_in[gs]  = in_den;
            assign side_in[gs] = in_side;
        end else begin : g_rest
            assign vld_in[gs]  = vld_reg[gs-1];
            assign rem_in[gs]  = rem_reg[gs-1];
            assign quo_in[gs]  = quo_reg[gs-1];
            assign den_in[gs]  = den_reg[gs-1];
            assign side_in[gs] = side_reg[gs-1];
        end

        assign den_sh = CW'(den_in[gs]) << K;

        always_comb begin
            rem_next[gs] = rem_in[gs];
            quo_next[gs] = quo_in[gs];
            for (int l = 0; l < LANES; l++) begin
                if (CW'(rem_in[gs][l]) >= den_sh) begin
                    rem_next[gs][l]    = NUM_W'(CW'(rem_in[gs][l]) - den_sh);
                    quo_next[gs][l][K] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[gs] <= 1'b0;
            end else if (en) begin
                vld_reg[gs] <= vld_in[gs];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[gs]  <= rem_next[gs];
                quo_reg[gs]  <= quo_next[gs];
                den_reg[gs]  <= den_in[gs];
                side_reg[gs] <= side_in[gs];
            end
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_quo   = quo_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

// ===== rtl/dtpl_lift.sv =====
module dtpl_lift (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  en,
    input  logic                                                  in_valid,
    input  logic [dtpl_pkg::DTPL_AMT_Q_W-1:0]                     in_amount,
    input  dtpl_pkg::dtpl_front_t                                 in_side,
    input  dtpl_pkg::dtpl_cfg_t                                   cfg,
    output logic                                                  out_valid,
    output logic [dtpl_pkg::DTPL_LANES-1:0][dtpl_pkg::DTPL_SCL_NUM_W-1:0] out_num,
    output logic [dtpl_pkg::DTPL_CH_W-1:0]                        out_den,
    output dtpl_pkg::dtpl_tail_t                                  out_side
);

    localparam int LW = dtpl_pkg::DTPL_POS_W + 3;
    localparam int GW = dtpl_pkg::DTPL_POS_W + 1;
    localparam int FW = dtpl_pkg::DTPL_SCL_FULL_W;
    localparam int SH = dtpl_pkg::DTPL_Q16_SHIFT;

    logic                                    s1_valid_reg;
    dtpl_pkg::dtpl_front_t                   s1_reg;
    logic [dtpl_pkg::DTPL_POS_W-1:0]         pos_reg;
    logic [dtpl_pkg::DTPL_POS_W-1:0]         pos_next;
    logic signed [dtpl_pkg::DTPL_CH_W:0]     diff;
    logic signed [LW-1:0]                    lifted;

    logic                                    s2_valid_reg;
    dtpl_pkg::dtpl_tail_t                    tail_reg;
    dtpl_pkg::dtpl_tail_t                    tail_next;
    logic [dtpl_pkg::DTPL_LANES-1:0][dtpl_pkg::DTPL_SCL_NUM_W-1:0] num_reg;
    logic [dtpl_pkg::DTPL_LANES-1:0][dtpl_pkg::DTPL_SCL_NUM_W-1:0] num_next;
    logic [dtpl_pkg::DTPL_CH_W-1:0]          den_reg;
    logic [dtpl_pkg::DTPL_CH_W-1:0]          den_next;
    logic [dtpl_pkg::DTPL_LANES-1:0][dtpl_pkg::DTPL_CH_W-1:0] chan;
    logic [FW-1:0]                           scaled [dtpl_pkg::DTPL_LANES];
    logic [GW-1:0]                           grey;

    // Stage one: lifted = v*2^16 + (target - v)*amount, clamped at zero.
    always_comb begin
        diff   = $signed({1'b0, cfg.target}) - $signed({1'b0, in_side.v});
        lifted = $signed(LW'({in_side.v, {SH{1'b0}}}))
               + LW'(diff) * LW'($signed({1'b0, in_amount}));
        pos_next = lifted[LW-1] ? '0 : lifted[dtpl_pkg::DTPL_POS_W-1:0];
    end

    // Stage two: per-channel dividend. Black uses divisor one with the
    // rounded grey level as dividend.
    always_comb begin
        chan[0] = s1_reg.pix.red;
        chan[1] = s1_reg.pix.green;
        chan[2] = s1_reg.pix.blue;
        grey    = (GW'(pos_reg) + (GW'(1) << (SH - 1))) >> SH;
        for (int l = 0; l < dtpl_pkg::DTPL_LANES; l++) begin
            scaled[l] = ((FW'(chan[l]) * FW'(pos_reg)) << 1)
                      + (FW'(s1_reg.v) << SH);
            if (s1_reg.v == '0) begin
                num_next[l] = dtpl_pkg::DTPL_SCL_NUM_W'(grey);
            end else begin
                num_next[l] = scaled[l][FW-1:SH+1];
            end
        end
        den_next       = (s1_reg.v == '0) ? dtpl_pkg::DTPL_CH_W'(1) : s1_reg.v;
        tail_next.pix  = s1_reg.pix;
        tail_next.pass = s1_reg.pass;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg   <= in_side;
            pos_reg  <= pos_next;
            tail_reg <= tail_next;
            num_reg  <= num_next;
            den_reg  <= den_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_side  = tail_reg;

endmodule
